FILE: hdl/bcr_pkg.sv
// shared types, register offsets and helpers for the board control register block
package bcr_pkg;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SIZE_W = 3;

  localparam int unsigned MEMORY_MEGABYTES_DEF = 16;

  // word offsets of the three registers
  localparam logic [ADDR_W-1:0] OFF_MEMCFG = 20'h00000;
  localparam logic [ADDR_W-1:0] OFF_CPUCFG = 20'h80000;
  localparam logic [ADDR_W-1:0] OFF_AUXCTL = 20'hE0000;

  // bit masks inside the registers
  localparam logic [7:0]  AUX_SELECT  = 8'h20;
  localparam logic [7:0]  AUX_CLOCK   = 8'h40;
  localparam logic [15:0] CFG_SERIAL  = 16'h0100;
  localparam logic [15:0] CFG_SOFTRST = 16'h0200;
  localparam logic [7:0]  SYSID_FPU   = 8'h02;

  // access size codes
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [7:0]  memory_config;
    logic [15:0] cpu_config;
    logic [7:0]  aux_control;
  } regs_t;

  typedef struct packed {
    mode_t             mode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] access_size;
    logic [DATA_W-1:0] write_data;
    logic              eeprom_data_pin;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              pin_update;
    logic              eeprom_select;
    logic              eeprom_clock;
    logic              eeprom_serial_in;
    logic              reset_request;
    logic              unmapped_access;
  } rsp_t;

  // memory config reset value from the installed memory size
  function automatic logic [7:0] memcfg_reset(input int unsigned mb);
    int unsigned v;
    begin
      if (mb >= 64) begin
        v = (((mb >> 4) - 1) & 32'h0F) | 32'h10;
      end else begin
        v = ((mb >> 2) - 1) & 32'h0F;
      end
      return v[7:0];
    end
  endfunction

endpackage

FILE: hdl/bcr_if.sv
// valid/ready channel interfaces for bus requests and results
interface bcr_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [19:0] address;
  logic [2:0]  access_size;
  logic [31:0] write_data;
  logic        eeprom_data_pin;

  modport source (output valid, mode, address, access_size, write_data, eeprom_data_pin,
                  input ready);
  modport sink (input valid, mode, address, access_size, write_data, eeprom_data_pin,
                output ready);
endinterface

interface bcr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        pin_update;
  logic        eeprom_select;
  logic        eeprom_clock;
  logic        eeprom_serial_in;
  logic        reset_request;
  logic        unmapped_access;

  modport source (output valid, read_data, pin_update, eeprom_select, eeprom_clock,
                  eeprom_serial_in, reset_request, unmapped_access, input ready);
  modport sink (input valid, read_data, pin_update, eeprom_select, eeprom_clock,
                eeprom_serial_in, reset_request, unmapped_access, output ready);
endinterface

FILE: hdl/bcr_decode.sv
// address decode, lane shifting and register update for one bus request
module bcr_decode (
  input  bcr_pkg::req_t  req,
  input  bcr_pkg::regs_t regs,
  output bcr_pkg::regs_t regs_nxt,
  output bcr_pkg::rsp_t  rsp
);
  import bcr_pkg::*;

  logic [ADDR_W-1:0] word_off;
  logic              hit_mem;
  logic              hit_cpu;
  logic              hit_aux;
  logic [4:0]        shift;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] wr_word;
  logic [7:0]        sysid;

  // word offset match
  assign word_off = {req.address[ADDR_W-1:2], 2'b00};
  assign hit_mem  = (word_off == OFF_MEMCFG);
  assign hit_cpu  = (word_off == OFF_CPUCFG);
  assign hit_aux  = (word_off == OFF_AUXCTL);

  // big-endian lane shift and size mask
  always_comb begin
    case (req.access_size)
      SIZE_BYTE: begin
        shift = {~req.address[1:0], 3'b000};
        mask  = 32'h0000_00FF;
      end
      SIZE_HALF: begin
        shift = {~req.address[1], 4'b0000};
        mask  = 32'h0000_FFFF;
      end
      default: begin
        shift = 5'd0;
        mask  = 32'hFFFF_FFFF;
      end
    endcase
  end

  // read word assembly
  assign sysid = {7'd0, req.eeprom_data_pin} | SYSID_FPU;
  always_comb begin
    rd_word = '0;
    if (hit_mem) begin
      rd_word = {regs.memory_config, sysid, 16'd0};
    end else if (hit_cpu) begin
      rd_word = {16'd0, regs.cpu_config};
    end else if (hit_aux) begin
      rd_word = {regs.aux_control, 24'd0};
    end
  end

  assign wr_word = (req.write_data & mask) << shift;

  // register update and result fields
  always_comb begin
    regs_nxt          = regs;
    rsp.read_data     = '0;
    rsp.pin_update    = 1'b0;
    rsp.reset_request = 1'b0;
    if (req.mode == MODE_WRITE) begin
      if (hit_mem) begin
        regs_nxt.memory_config = wr_word[31:24];
      end else if (hit_cpu) begin
        regs_nxt.cpu_config = wr_word[15:0];
        rsp.pin_update      = 1'b1;
        rsp.reset_request   = ((wr_word[15:0] & CFG_SOFTRST) != 16'd0) &&
                              ((regs.cpu_config & CFG_SOFTRST) == 16'd0);
      end else if (hit_aux) begin
        regs_nxt.aux_control = wr_word[31:24];
        rsp.pin_update       = 1'b1;
      end
    end else begin
      rsp.read_data = (rd_word >> shift) & mask;
    end
    rsp.eeprom_select    = (regs_nxt.aux_control & AUX_SELECT) != 8'd0;
    rsp.eeprom_clock     = (regs_nxt.aux_control & AUX_CLOCK) != 8'd0;
    rsp.eeprom_serial_in = (regs_nxt.cpu_config & CFG_SERIAL) != 16'd0;
    rsp.unmapped_access  = !(hit_mem || hit_cpu || hit_aux);
  end

endmodule

FILE: hdl/board_control_register_block.sv
// top level: request register, decode and result register of the control block
// a request waits in the request register and moves into the result register once that one is free
// throughput: one request per cycle; input ready follows output ready when both stages are full
// the register update and decode sit in a single stage between those two registers
// reset (rst_n low, synchronous): both stages empty, cpu config and aux control zero,
// memory config set from the installed memory size
module board_control_register_block #(
  parameter int unsigned MEMORY_MEGABYTES = bcr_pkg::MEMORY_MEGABYTES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  bcr_req_if.sink   in_req,
  bcr_rsp_if.source out_rsp
);
  import bcr_pkg::*;

  localparam logic [7:0] MEMCFG_RST = memcfg_reset(MEMORY_MEGABYTES);

  logic  req_valid_r;
  req_t  req_r;
  logic  out_valid_r;
  rsp_t  rsp_r;
  regs_t regs_r;
  regs_t regs_nxt;
  rsp_t  rsp_nxt;
  logic  advance;
  logic  in_fire;

  // pipeline control
  assign advance      = req_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !req_valid_r || advance;
  assign in_fire      = in_req.valid && in_req.ready;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
    if (in_fire) begin
      req_r.mode            <= mode_t'(in_req.mode);
      req_r.address         <= in_req.address;
      req_r.access_size     <= in_req.access_size;
      req_r.write_data      <= in_req.write_data;
      req_r.eeprom_data_pin <= in_req.eeprom_data_pin;
    end
  end

  bcr_decode u_decode (
    .req      (req_r),
    .regs     (regs_r),
    .regs_nxt (regs_nxt),
    .rsp      (rsp_nxt)
  );

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.memory_config <= MEMCFG_RST;
      regs_r.cpu_config    <= '0;
      regs_r.aux_control   <= '0;
    end else if (advance) begin
      regs_r <= regs_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.read_data        = rsp_r.read_data;
  assign out_rsp.pin_update       = rsp_r.pin_update;
  assign out_rsp.eeprom_select    = rsp_r.eeprom_select;
  assign out_rsp.eeprom_clock     = rsp_r.eeprom_clock;
  assign out_rsp.eeprom_serial_in = rsp_r.eeprom_serial_in;
  assign out_rsp.reset_request    = rsp_r.reset_request;
  assign out_rsp.unmapped_access  = rsp_r.unmapped_access;

  // a reset request only comes from a cpu config write
  a_rst_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!rsp_r.reset_request || rsp_r.pin_update))
    else $error("reset request without pin update");

  // an unknown offset never drives the pins
  a_unmapped_no_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rsp_r.unmapped_access |-> !rsp_r.pin_update)
    else $error("unmapped access updated pins");

  // a request moving out of the input stage always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded");

  // a held request moves on whenever the result register is free
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && !out_valid_r |-> advance)
    else $error("request stalled with empty result register");

  // registers change only when a request is processed
  a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(regs_r))
    else $error("registers changed without a request");

endmodule

FILE: dv/bcr_checker.sv
// request/result monitor with a register-level predictor for the board control block
`timescale 1ns / 100ps

module bcr_checker #(
  parameter int unsigned MEM_MB = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bcr_req_if          req_mon,
  bcr_rsp_if          rsp_mon,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned requests_seen,
  output int unsigned results_seen,
  output int unsigned resets_seen,
  output int unsigned unmapped_seen
);
  import bcr_pkg::*;

  // predicted register contents
  logic [7:0]  memcfg_q;
  logic [15:0] cpucfg_q;
  logic [7:0]  auxctl_q;

  // results still owed by the block, oldest first
  rsp_t pending_results[$];

  // memory config byte after reset, from the installed size
  function automatic logic [7:0] memcfg_after_reset();
    int unsigned v;
    if (MEM_MB >= 64) begin
      v = ((MEM_MB / 16 - 1) & 32'h0F) | 32'h10;
    end else begin
      v = (MEM_MB / 4 - 1) & 32'h0F;
    end
    return v[7:0];
  endfunction

  // apply one bus access to the register copy and return its result
  function automatic rsp_t predict_access(input req_t r);
    logic [ADDR_W-1:0] word_off;
    int unsigned       sh;
    logic [31:0]       mask;
    logic [31:0]       w;
    rsp_t              res;
    word_off = {r.address[ADDR_W-1:2], 2'b00};
    res = '0;
    // byte lane selection, big-endian
    case (r.access_size)
      SIZE_BYTE: begin
        sh   = 8 * (3 - int'(r.address[1:0]));
        mask = 32'h0000_00FF;
      end
      SIZE_HALF: begin
        sh   = r.address[1] ? 0 : 16;
        mask = 32'h0000_FFFF;
      end
      default: begin
        sh   = 0;
        mask = 32'hFFFF_FFFF;
      end
    endcase
    res.unmapped_access = !(word_off == OFF_MEMCFG || word_off == OFF_CPUCFG ||
                            word_off == OFF_AUXCTL);
    if (r.mode == MODE_READ) begin
      case (word_off)
        OFF_MEMCFG: w = {memcfg_q, SYSID_FPU | {7'b0, r.eeprom_data_pin}, 16'h0000};
        OFF_CPUCFG: w = {16'h0000, cpucfg_q};
        OFF_AUXCTL: w = {auxctl_q, 24'h000000};
        default:    w = 32'h0;
      endcase
      res.read_data = (w >> sh) & mask;
    end else begin
      // sub-word writes zero the other lanes of the word
      w = (r.write_data & mask) << sh;
      case (word_off)
        OFF_MEMCFG: memcfg_q = w[31:24];
        OFF_CPUCFG: begin
          res.pin_update    = 1'b1;
          res.reset_request = |(w[15:0] & CFG_SOFTRST) && !(|(cpucfg_q & CFG_SOFTRST));
          cpucfg_q          = w[15:0];
        end
        OFF_AUXCTL: begin
          res.pin_update = 1'b1;
          auxctl_q       = w[31:24];
        end
        default: ;
      endcase
    end
    // pin levels always reflect the registers after this access
    res.eeprom_select    = |(auxctl_q & AUX_SELECT);
    res.eeprom_clock     = |(auxctl_q & AUX_CLOCK);
    res.eeprom_serial_in = |(cpucfg_q & CFG_SERIAL);
    return res;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    req_t r;
    rsp_t got;
    rsp_t want;
    if (!rst_n) begin
      memcfg_q      = memcfg_after_reset();
      cpucfg_q      = '0;
      auxctl_q      = '0;
      pending_results.delete();
      mismatches    = 0;
      requests_seen = 0;
      results_seen  = 0;
      resets_seen   = 0;
      unmapped_seen = 0;
    end else begin
      // compare a result against the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.read_data        = rsp_mon.read_data;
        got.pin_update       = rsp_mon.pin_update;
        got.eeprom_select    = rsp_mon.eeprom_select;
        got.eeprom_clock     = rsp_mon.eeprom_clock;
        got.eeprom_serial_in = rsp_mon.eeprom_serial_in;
        got.reset_request    = rsp_mon.reset_request;
        got.unmapped_access  = rsp_mon.unmapped_access;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d with nothing outstanding: data %h flags %b",
                     $realtime, results_seen, got.read_data, got[5:0]);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d (flags upd/sel/clk/si/rst/unm) expected %h %b, got %h %b",
                       $realtime, results_seen, want.read_data, want[5:0],
                       got.read_data, got[5:0]);
            end
          end
        end
      end
      // predict every accepted request
      if (req_mon.valid && req_mon.ready) begin
        r.mode            = mode_t'(req_mon.mode);
        r.address         = req_mon.address;
        r.access_size     = req_mon.access_size;
        r.write_data      = req_mon.write_data;
        r.eeprom_data_pin = req_mon.eeprom_data_pin;
        want = predict_access(r);
        requests_seen++;
        if (want.reset_request) resets_seen++;
        if (want.unmapped_access) unmapped_seen++;
        pending_results.push_back(want);
      end
    end
    pending = pending_results.size();
  end

endmodule

FILE: dv/testbench.sv
// stimulus, flow control and verdict for the board control register block
`timescale 1ns / 100ps

module testbench;
  import bcr_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_ODD  = 3'd3;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT  = 50000;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned QUIET_FIRST  = 300;
  localparam int unsigned QUIET_LAST   = 450;
  localparam int unsigned PAUSE_AT     = 600;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;

  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned requests_seen;
  int unsigned results_seen;
  int unsigned resets_seen;
  int unsigned unmapped_seen;

  bcr_req_if in_req ();
  bcr_rsp_if out_rsp ();

  board_control_register_block i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  bcr_checker #(
    .MEM_MB (MEMORY_MEGABYTES_DEF)
  ) i_bus_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_req),
    .rsp_mon       (out_rsp),
    .mismatches    (mismatches),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .resets_seen   (resets_seen),
    .unmapped_seen (unmapped_seen)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit in_quiet_stretch();
    return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
  endfunction

  // result side: random stalls, one long hold-off, a stretch without stalls
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_rsp.ready = 1'b0;
        hold_left--;
      end else if (in_quiet_stretch()) begin
        out_rsp.ready = 1'b1;
      end else begin
        out_rsp.ready = ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // offer one request, with random idle cycles ahead of it; called at a falling edge
  task automatic send_req(input mode_t m, input logic [ADDR_W-1:0] a,
                          input logic [SIZE_W-1:0] s, input logic [DATA_W-1:0] d,
                          input logic pin);
    while (!in_quiet_stretch() && $urandom_range(0, 99) < 15) begin
      in_req.valid = 1'b0;
      @(negedge clk);
    end
    in_req.valid           = 1'b1;
    in_req.mode            = m;
    in_req.address         = a;
    in_req.access_size     = s;
    in_req.write_data      = d;
    in_req.eeprom_data_pin = pin;
    do @(posedge clk); while (!in_req.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // stop offering until the block has returned everything
  task automatic drain_results();
    in_req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mostly register hits with random lanes, some neighbors and random offsets
  task automatic send_random_req();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    int unsigned       pick;
    case ($urandom_range(0, 2))
      0:       base = OFF_MEMCFG;
      1:       base = OFF_CPUCFG;
      default: base = OFF_AUXCTL;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      a = ADDR_W'($urandom_range(0, 20'hFFFFF));
    end else if (pick < 28) begin
      a = $urandom_range(0, 1) ? base + 20'd4 : base - 20'd4;
    end else begin
      a = base | ADDR_W'($urandom_range(0, 3));
    end
    send_req($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, a,
             SIZE_W'($urandom_range(1, 4)), $urandom, 1'($urandom_range(0, 1)));
  endtask

  // reset, directed accesses, random accesses, verdict
  initial begin
    in_req.valid           = 1'b0;
    in_req.mode            = MODE_READ;
    in_req.address         = '0;
    in_req.access_size     = SIZE_WORD;
    in_req.write_data      = '0;
    in_req.eeprom_data_pin = 1'b0;
    rst_n                  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // memory config word with the system id lane
    send_req(MODE_READ,  OFF_MEMCFG,          SIZE_WORD, 32'h0, 1'b0);
    send_req(MODE_READ,  OFF_MEMCFG + 20'd1,  SIZE_BYTE, 32'h0, 1'b1);
    send_req(MODE_READ,  OFF_MEMCFG,          SIZE_HALF, 32'h0, 1'b1);
    send_req(MODE_READ,  OFF_MEMCFG + 20'd3,  SIZE_BYTE, 32'h0, 1'b1);
    // soft-reset bit edges and serial data pin
    send_req(MODE_WRITE, OFF_CPUCFG,          SIZE_WORD, 32'hFFFF_FFFF, 1'b0);
    send_req(MODE_WRITE, OFF_CPUCFG,          SIZE_WORD, 32'h0000_0300, 1'b1);
    send_req(MODE_WRITE, OFF_CPUCFG,          SIZE_WORD, 32'h0000_0000, 1'b0);
    send_req(MODE_WRITE, OFF_CPUCFG + 20'd2,  SIZE_HALF, 32'hFFFF_0200, 1'b0);
    send_req(MODE_WRITE, OFF_CPUCFG + 20'd3,  SIZE_BYTE, 32'h0000_0001, 1'b0);
    send_req(MODE_WRITE, OFF_CPUCFG + 20'd2,  SIZE_BYTE, 32'hFFFF_FF03, 1'b0);
    send_req(MODE_READ,  OFF_CPUCFG + 20'd2,  SIZE_BYTE, 32'h0, 1'b0);
    send_req(MODE_READ,  OFF_CPUCFG + 20'd3,  SIZE_HALF, 32'h0, 1'b0);
    send_req(MODE_READ,  OFF_CPUCFG,          SIZE_HALF, 32'h0, 1'b1);
    // aux control: select and clock, then cleared through another lane
    send_req(MODE_WRITE, OFF_AUXCTL,          SIZE_BYTE, 32'h0000_0060, 1'b0);
    send_req(MODE_READ,  OFF_AUXCTL,          SIZE_WORD, 32'h0, 1'b0);
    send_req(MODE_WRITE, OFF_AUXCTL + 20'd1,  SIZE_BYTE, 32'h0000_00FF, 1'b0);
    // memory config overwrite, then cleared by a write to the low half
    send_req(MODE_WRITE, OFF_MEMCFG,          SIZE_WORD, 32'hA5FF_FFFF, 1'b1);
    send_req(MODE_READ,  OFF_MEMCFG,          SIZE_BYTE, 32'h0, 1'b0);
    send_req(MODE_WRITE, OFF_MEMCFG + 20'd2,  SIZE_HALF, 32'h0000_FFFF, 1'b0);
    // unmapped offsets and the odd access size
    send_req(MODE_READ,  20'hFFFFF,           SIZE_BYTE, 32'h0, 1'b1);
    send_req(MODE_WRITE, OFF_MEMCFG + 20'd4,  SIZE_WORD, 32'hFFFF_FFFF, 1'b1);
    send_req(MODE_READ,  OFF_CPUCFG - 20'd4,  SIZE_ODD,  32'h0, 1'b0);
    send_req(MODE_READ,  OFF_CPUCFG,          SIZE_ODD,  32'h0, 1'b0);
    send_req(MODE_WRITE, OFF_AUXCTL,          SIZE_ODD,  32'hFF00_0000, 1'b0);
    send_req(MODE_READ,  OFF_AUXCTL + 20'd2,  SIZE_HALF, 32'h0, 1'b0);
    drain_results();

    // random accesses, with one full drain partway through
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) drain_results();
      send_random_req();
    end

    // wait out the last results, then watch for stray ones
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests and compared %0d results", requests_seen, results_seen);
    $display("including %0d soft-reset requests and %0d unmapped accesses",
             resets_seen, unmapped_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
